FILE: rtl/todrm_pkg.sv
// Shared types and constants for the trigger object delta R match block.
// Depends on nothing; the top level takes its names by package scope.
`timescale 1ns / 1ps

package todrm_pkg;

   // Coordinate fixed point: signed, COORD_FRAC_BITS fraction bits.
   localparam int COORD_FRAC_BITS = 8;

   localparam int ETA_W = 12;
   localparam int PHI_W = 11;

   // pi * 2^32 rounded, brought to the coordinate scale with round half up.
   localparam longint unsigned PI_SCALED_32 = 64'd13493037705;
   localparam int PI_SHIFT = 32 - COORD_FRAC_BITS;
   localparam int PI_Q = int'((PI_SCALED_32 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT);
   localparam int TWO_PI_Q = 2 * PI_Q;

   // Difference widths: one bit more than the operands.
   localparam int DETA_W = ETA_W + 1;
   localparam int DPHI_W = PHI_W + 1;

   // Squares and their sum, all non-negative.
   localparam int DETA_SQ_W = 2 * DETA_W - 2;
   localparam int DPHI_SQ_W = 2 * DPHI_W - 2;
   localparam int SUM_W = DETA_SQ_W + 1;

   // Both sides of the compare are scaled to units of 2^-24.
   localparam int LHS_SHIFT = 24 - 2 * COORD_FRAC_BITS;
   localparam int RADIUS_W = 16;
   localparam int RHS_SHIFT = 24 - RADIUS_W;
   localparam int CMP_W = SUM_W + LHS_SHIFT;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_LSB = 2;

   typedef enum logic [0:0] {
      REG_MATCH_RADIUS_SQ = 1'b0,
      REG_UNUSED          = 1'b1
   } reg_index_type;

   localparam logic [RADIUS_W-1:0] MATCH_RADIUS_SQ_RESET = 16'd5898;

   // One input transfer as held in the input register.
   typedef struct packed {
      logic signed [ETA_W-1:0] muon_eta;
      logic signed [PHI_W-1:0] muon_phi;
      logic signed [ETA_W-1:0] object_eta;
      logic signed [PHI_W-1:0] object_phi;
      logic                    object_valid;
      logic                    last_object;
   } item_type;

endpackage

FILE: rtl/trigger_object_delta_r_match.sv
// Top level of the trigger object delta R match block: input register,
// distance test, sticky match flag and result register. Uses todrm_pkg.
`timescale 1ns / 1ps

// Takes one transfer per clock: the muon (eta, phi) and one trigger object,
// with object_valid and last_object. Each valid object is tested for
// deta^2 + dphi^2 < match_radius_squared, phi wrapped once into (-pi, pi];
// a sticky flag collects any match of the list, and the item marked last
// produces one result transfer carrying the flag (including its own match)
// and clears it. An empty list is one invalid last item and yields 0.
// From input transfer to result, an item passes the input register, then the
// distance test (two small squarers, one add, one compare) and the result
// register. Sustained rate is one item per clock; a waiting result holds the
// input register only when the next item there is also a last item. The radius
// register sits at byte address 0 of the APB port (reset 5898, i.e. 0.09 in
// units of 1/65536); write it only while no list is in flight.
module trigger_object_delta_r_match (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [todrm_pkg::ETA_W-1:0]       req_muon_eta,
   input  logic signed [todrm_pkg::PHI_W-1:0]       req_muon_phi,
   input  logic signed [todrm_pkg::ETA_W-1:0]       req_object_eta,
   input  logic signed [todrm_pkg::PHI_W-1:0]       req_object_phi,
   input  logic                                     req_object_valid,
   input  logic                                     req_last_object,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_matched,

   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [todrm_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [todrm_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [todrm_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                     csr_pready
);

   // Configuration register.
   logic [todrm_pkg::RADIUS_W-1:0] radius_sq_ff;
   logic [todrm_pkg::RADIUS_W-1:0] radius_sq_in;
   todrm_pkg::reg_index_type       csr_index;
   logic                           csr_write;

   // Input register.
   todrm_pkg::item_type item_ff;
   todrm_pkg::item_type item_in;
   logic                item_valid_ff;
   logic                item_valid_in;

   // Sticky flag and result register.
   logic match_seen_ff;
   logic match_seen_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_matched_ff;
   logic rsp_matched_in;

   // Handshake terms.
   logic req_take;
   logic rsp_take;
   logic item_advance;
   logic item_emits;

   // Distance test.
   logic signed [todrm_pkg::DETA_W-1:0]     deta;
   logic signed [todrm_pkg::DPHI_W-1:0]     dphi_raw;
   logic signed [todrm_pkg::DPHI_W-1:0]     dphi;
   logic signed [2*todrm_pkg::DETA_W-1:0]   deta_sq_full;
   logic signed [2*todrm_pkg::DPHI_W-1:0]   dphi_sq_full;
   logic [todrm_pkg::SUM_W-1:0]             dist_sq;
   logic [todrm_pkg::CMP_W-1:0]             lhs;
   logic [todrm_pkg::CMP_W-1:0]             rhs;
   logic                                    hit;

   localparam logic signed [todrm_pkg::DPHI_W-1:0] PI_D =
      todrm_pkg::DPHI_W'(todrm_pkg::PI_Q);
   localparam logic signed [todrm_pkg::DPHI_W-1:0] TWO_PI_D =
      todrm_pkg::DPHI_W'(todrm_pkg::TWO_PI_Q);

   // ---------------------------------------------------------------------
   // APB port: always ready, write on the access phase.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = todrm_pkg::reg_index_type'(csr_paddr[todrm_pkg::CSR_INDEX_LSB]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      radius_sq_in = radius_sq_ff;
      if (csr_write && csr_index == todrm_pkg::REG_MATCH_RADIUS_SQ) begin
         radius_sq_in = csr_pwdata[todrm_pkg::RADIUS_W-1:0];
      end
   end

   always_comb begin
      case (csr_index)
         todrm_pkg::REG_MATCH_RADIUS_SQ: begin
            csr_prdata = todrm_pkg::CSR_DATA_W'(radius_sq_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Flow control. Non-last items always leave the input register; a last
   // item leaves only when the result register is free or being drained.
   // ---------------------------------------------------------------------
   assign rsp_take     = rsp_valid_ff && !rsp_stall;
   assign item_emits   = item_valid_ff && item_ff.last_object;
   assign item_advance = !item_ff.last_object || !rsp_valid_ff || !rsp_stall;
   assign req_stall    = item_valid_ff && !item_advance;
   assign req_take     = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Distance test on the held item.
   // ---------------------------------------------------------------------
   assign deta     = {item_ff.muon_eta[todrm_pkg::ETA_W-1], item_ff.muon_eta}
                   - {item_ff.object_eta[todrm_pkg::ETA_W-1], item_ff.object_eta};
   assign dphi_raw = {item_ff.muon_phi[todrm_pkg::PHI_W-1], item_ff.muon_phi}
                   - {item_ff.object_phi[todrm_pkg::PHI_W-1], item_ff.object_phi};

   // Wrap once into (-pi, pi]; out-of-range inputs may stay outside.
   always_comb begin
      if (dphi_raw > PI_D) begin
         dphi = dphi_raw - TWO_PI_D;
      end else if (dphi_raw <= -PI_D) begin
         dphi = dphi_raw + TWO_PI_D;
      end else begin
         dphi = dphi_raw;
      end
   end

   assign deta_sq_full = deta * deta;
   assign dphi_sq_full = dphi * dphi;
   assign dist_sq = todrm_pkg::SUM_W'(deta_sq_full[todrm_pkg::DETA_SQ_W-1:0])
                  + todrm_pkg::SUM_W'(dphi_sq_full[todrm_pkg::DPHI_SQ_W-1:0]);

   // Compare in units of 2^-24, strictly less than.
   assign lhs = todrm_pkg::CMP_W'(dist_sq) << todrm_pkg::LHS_SHIFT;
   assign rhs = todrm_pkg::CMP_W'(radius_sq_ff) << todrm_pkg::RHS_SHIFT;
   assign hit = item_ff.object_valid && (lhs < rhs);

   // ---------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------
   always_comb begin
      // Input register: load on transfer, drop once the held item leaves.
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (item_valid_ff && item_advance) begin
         item_valid_in = 1'b0;
      end
      if (req_take) begin
         item_valid_in = 1'b1;
         item_in.muon_eta     = req_muon_eta;
         item_in.muon_phi     = req_muon_phi;
         item_in.object_eta   = req_object_eta;
         item_in.object_phi   = req_object_phi;
         item_in.object_valid = req_object_valid;
         item_in.last_object  = req_last_object;
      end

      // Sticky flag: collect hits, clear when the last item leaves.
      match_seen_in = match_seen_ff;
      if (item_valid_ff && item_advance) begin
         if (item_ff.last_object) begin
            match_seen_in = 1'b0;
         end else if (hit) begin
            match_seen_in = 1'b1;
         end
      end

      // Result register: drain on transfer, load when a last item leaves.
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (item_emits && item_advance) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = match_seen_ff || hit;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff  <= todrm_pkg::MATCH_RADIUS_SQ_RESET;
         item_valid_ff <= 1'b0;
         match_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         radius_sq_ff  <= radius_sq_in;
         item_valid_ff <= item_valid_in;
         match_seen_ff <= match_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for trigger_object_delta_r_match: a scoreboard class
// predicts the per-list match flag, plain tasks drive the item, result and APB ports.
// Depends on rtl/todrm_pkg.sv and rtl/trigger_object_delta_r_match.sv.
`timescale 1ns / 1ps

module testbench;

   // Radius register value after reset: 0.09 in units of 1/65536.
   localparam logic [15:0] RADIUS_SQ_AT_RESET = 16'd5898;
   // pi in coordinate units, from pi * 2^32 with round half up.
   localparam longint HALF_TURN =
      longint'((64'd13493037705 + (64'd1 << (31 - todrm_pkg::COORD_FRAC_BITS)))
               >> (32 - todrm_pkg::COORD_FRAC_BITS));
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 400;

   localparam logic [todrm_pkg::CSR_ADDR_W-1:0] ADDR_RADIUS =
      {todrm_pkg::REG_MATCH_RADIUS_SQ, 2'b00};

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   // Tracks the sticky match flag per list and the flags still owed by the block.
   class match_scoreboard;
      logic [15:0] radius_sq = RADIUS_SQ_AT_RESET;
      bit          hit_seen = 1'b0;
      bit          pending_flags[$];
      int          errors = 0;
      int          checked = 0;

      function void write_register(todrm_pkg::reg_index_type idx,
                                   logic [todrm_pkg::CSR_DATA_W-1:0] value);
         // An index past the register list is dropped by the block.
         if (idx == todrm_pkg::REG_MATCH_RADIUS_SQ)
            radius_sq = value[15:0];
      endfunction

      function bit inside_radius(todrm_pkg::item_type it);
         longint deta;
         longint dphi;
         longint dr2;
         deta = longint'($signed(it.muon_eta)) - longint'($signed(it.object_eta));
         dphi = longint'($signed(it.muon_phi)) - longint'($signed(it.object_phi));
         // Wrap once only; an out-of-range phi may stay outside (-pi, pi].
         if (dphi > HALF_TURN)
            dphi = dphi - 2 * HALF_TURN;
         else if (dphi <= -HALF_TURN)
            dphi = dphi + 2 * HALF_TURN;
         dr2 = deta * deta + dphi * dphi;
         return (dr2 << (24 - 2 * todrm_pkg::COORD_FRAC_BITS)) < (longint'(radius_sq) << 8);
      endfunction

      function void note_item(todrm_pkg::item_type it);
         if (it.object_valid && inside_radius(it))
            hit_seen = 1'b1;
         if (it.last_object) begin
            pending_flags.insert(pending_flags.size(), hit_seen);
            hit_seen = 1'b0;
         end
      endfunction

      function void check_matched(logic got);
         bit want;
         checked++;
         if (pending_flags.size() == 0) begin
            errors++;
            $display("%0t: result transfer matched=%0b, expected none", $time, got);
         end else begin
            want = pending_flags.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: matched mismatch: expected %0b, actual %0b",
                        $time, want, got);
            end
         end
      endfunction

      function bit idle();
         return pending_flags.size() == 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                               req_valid;
   logic                               req_stall;
   logic signed [todrm_pkg::ETA_W-1:0] req_muon_eta;
   logic signed [todrm_pkg::PHI_W-1:0] req_muon_phi;
   logic signed [todrm_pkg::ETA_W-1:0] req_object_eta;
   logic signed [todrm_pkg::PHI_W-1:0] req_object_phi;
   logic                               req_object_valid;
   logic                               req_last_object;

   logic rsp_valid;
   logic rsp_stall;
   logic rsp_matched;

   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [todrm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [todrm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [todrm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   match_scoreboard sb = new;

   int             burst_left = 0;
   int             cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   trigger_object_delta_r_match uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_muon_eta     (req_muon_eta),
      .req_muon_phi     (req_muon_phi),
      .req_object_eta   (req_object_eta),
      .req_object_phi   (req_object_phi),
      .req_object_valid (req_object_valid),
      .req_last_object  (req_last_object),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Result side: check every accepted transfer against the oldest expected flag,
   // then pick the next stall value. Stall modes change at random intervals, so
   // stretches without any stall alternate with light, heavy and toggling stalls.
   // Once, after 60 results, hold off for a long stretch so that the block fills
   // up and pushes back on the item side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_matched(rsp_matched);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && sb.checked >= 60) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left = mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Offer one item and hold it until the block takes it. Items go out in bursts;
   // between bursts drop valid for a random gap.
   task automatic send_item(input todrm_pkg::item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid        <= 1'b1;
      req_muon_eta     <= it.muon_eta;
      req_muon_phi     <= it.muon_phi;
      req_object_eta   <= it.object_eta;
      req_object_phi   <= it.object_phi;
      req_object_valid <= it.object_valid;
      req_last_object  <= it.last_object;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      burst_left = burst_left - 1;
   endtask

   // Pack raw coordinates (truncated to the port widths) into one item.
   task automatic send_fields(input int me, input int mp, input int oe, input int op,
                              input bit valid_obj, input bit last_obj);
      todrm_pkg::item_type it;
      it.muon_eta     = me[todrm_pkg::ETA_W-1:0];
      it.muon_phi     = mp[todrm_pkg::PHI_W-1:0];
      it.object_eta   = oe[todrm_pkg::ETA_W-1:0];
      it.object_phi   = op[todrm_pkg::PHI_W-1:0];
      it.object_valid = valid_obj;
      it.last_object  = last_obj;
      send_item(it);
   endtask

   // Drop valid and wait until every expected flag has come back, then let the
   // pipeline drain an item that produced no result.
   task automatic settle();
      req_valid <= 1'b0;
      while (!sb.idle()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB transfer: setup phase, access phase until pready, then an idle phase.
   task automatic apb_transfer(input bit write,
                               input logic [todrm_pkg::CSR_ADDR_W-1:0] addr,
                               input logic [todrm_pkg::CSR_DATA_W-1:0] wdata,
                               output logic [todrm_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register, then read the radius back and compare with the prediction.
   task automatic csr_write(input todrm_pkg::reg_index_type idx,
                            input logic [todrm_pkg::CSR_DATA_W-1:0] value);
      logic [todrm_pkg::CSR_DATA_W-1:0] rdata;
      logic [todrm_pkg::CSR_DATA_W-1:0] want;
      apb_transfer(1'b1, {idx, 2'b00}, value, rdata);
      sb.write_register(idx, value);
      apb_transfer(1'b0, ADDR_RADIUS, '0, rdata);
      want = {{(todrm_pkg::CSR_DATA_W - 16){1'b0}}, sb.radius_sq};
      if (rdata !== want) begin
         sb.errors++;
         $display("%0t: radius readback mismatch: expected %0d, actual %0d",
                  $time, want, rdata);
      end
   endtask

   // Random lists: the muon stays fixed within a list, objects land near it, across
   // the phi seam, or anywhere in the port range. Some lists are empty, some items
   // carry no object. Count only the items the block does not ignore.
   task automatic run_lists(input int target);
      int sent;
      int len;
      int me;
      int mp;
      int oe;
      int op;
      bit valid_obj;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 7) == 0) begin
            me = $urandom_range(0, 4095) - 2048;
            mp = $urandom_range(0, 2047) - 1024;
         end else begin
            me = $urandom_range(0, 2560) - 1280;
            mp = $urandom_range(0, 1608) - 804;
         end
         if ($urandom_range(0, 11) == 0) begin
            send_fields(me, mp, $urandom_range(0, 4095), $urandom_range(0, 2047), 1'b0, 1'b1);
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     oe = me + $urandom_range(0, 200) - 100;
                     op = mp + $urandom_range(0, 200) - 100;
                  end
                  2: begin
                     oe = me + $urandom_range(0, 120) - 60;
                     op = mp + $urandom_range(0, 120) - 60 + ((mp >= 0) ? -1608 : 1608);
                  end
                  default: begin
                     oe = $urandom_range(0, 4095) - 2048;
                     op = $urandom_range(0, 2047) - 1024;
                  end
               endcase
               valid_obj = ($urandom_range(0, 9) != 0);
               send_fields(me, mp, oe, op, valid_obj, k == len - 1);
               if (valid_obj || k == len - 1)
                  sent++;
            end
         end
      end
   endtask

   initial begin
      logic [15:0] phase_radius[5];
      phase_radius = '{16'd0, 16'hFFFF, RADIUS_SQ_AT_RESET, 16'd0, 16'd2000};
      phase_radius[3] = $urandom_range(0, 65535);

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_muon_eta     <= '0;
      req_muon_phi     <= '0;
      req_object_eta   <= '0;
      req_object_phi   <= '0;
      req_object_valid <= 1'b0;
      req_last_object  <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      rsp_stall        <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lists under the radius left by reset.
      send_fields(0, 0, 0, 0, 1'b0, 1'b1);                 // empty list
      send_fields(100, -50, 100, -50, 1'b1, 1'b1);         // same spot
      send_fields(0, 0, 0, 0, 1'b0, 1'b0);                 // object-less item is ignored
      send_fields(0, 0, 500, 0, 1'b1, 1'b1);
      send_fields(10, 10, 20, 20, 1'b1, 1'b0);             // flag sticks past misses
      send_fields(10, 10, 900, -700, 1'b1, 1'b0);
      send_fields(10, 10, -900, 700, 1'b1, 1'b1);
      send_fields(-1280, 804, 1280, -804, 1'b1, 1'b0);     // match only on the last item
      send_fields(-1280, 804, -1250, -804, 1'b1, 1'b1);
      send_fields(5, 5, 5, 5, 1'b1, 1'b0);                 // list closed by an empty last
      send_fields(0, 0, 0, 0, 1'b0, 1'b1);
      send_fields(0, -800, 0, 800, 1'b1, 1'b1);            // wrap from below
      send_fields(0, 804, 0, 0, 1'b1, 1'b1);               // dphi of exactly +pi stays
      send_fields(0, -804, 0, 0, 1'b1, 1'b1);              // dphi of exactly -pi wraps
      send_fields(76, 0, 0, 0, 1'b1, 1'b1);                // just inside
      send_fields(0, 0, 77, 0, 1'b1, 1'b1);                // just outside
      send_fields(-2048, -1024, 2047, 1023, 1'b1, 1'b1);   // port extremes
      send_fields(2047, 1023, -2048, -1024, 1'b1, 1'b1);
      send_fields(-2048, -1024, -2048, -1024, 1'b1, 1'b1);
      settle();

      // A sum equal to the radius does not match; one below does.
      csr_write(todrm_pkg::REG_MATCH_RADIUS_SQ, 32'd100);
      send_fields(6, 0, 0, 8, 1'b1, 1'b1);
      send_fields(6, 0, 0, 7, 1'b1, 1'b1);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         // Write the unused index once: the radius must not move.
         if (phase == 2)
            csr_write(todrm_pkg::REG_UNUSED, $urandom());
         csr_write(todrm_pkg::REG_MATCH_RADIUS_SQ, {16'd0, phase_radius[phase]});
         run_lists(150);
         settle();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.idle())
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
